// ----- hdl/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// LALR parse step package
// Shared widths, table sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int NUM_STATES      = 512;
    localparam int NUM_SYMBOLS     = 128;
    localparam int NUM_PRODUCTIONS = 256;
    localparam int STACK_DEPTH     = 64;
    localparam int MAX_HANDLE      = 15;

    localparam int STATE_W = 9;
    localparam int SYM_W   = 7;
    localparam int KIND_W  = 3;
    localparam int PROD_W  = 8;
    localparam int HEAD_W  = 7;
    localparam int LEN_W   = 4;
    localparam int SP_W    = 7;
    localparam int STAT_W  = 3;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam int ACT_AW    = STATE_W + SYM_W;
    localparam int ACT_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int ACT_DW    = KIND_W + STATE_W;
    localparam int PROD_DW   = HEAD_W + LEN_W + 1;
    localparam int STK_AW    = $clog2(STACK_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_TRIM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_TOKEN     = 2'd0,
        REQ_WR_ACTION = 2'd1,
        REQ_WR_PROD   = 2'd2,
        REQ_RESTART   = 2'd3
    } t_req;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 3'd0,
        KIND_SHIFT  = 3'd1,
        KIND_REDUCE = 3'd2,
        KIND_GOTO   = 3'd3,
        KIND_ACCEPT = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        RES_SHIFT      = 3'd0,
        RES_RED_NORMAL = 3'd1,
        RES_RED_ELIM   = 3'd2,
        RES_ACCEPT     = 3'd3,
        RES_SYNTAX     = 3'd4,
        RES_INTERNAL   = 3'd5,
        RES_DONE       = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACT,
        S_PROD,
        S_TOP,
        S_GOTO,
        S_RESP
    } t_fsm;

    typedef struct packed {
        logic    clear_en;
        logic    act_rd_token;
        logic    wr_action;
        logic    wr_prod;
        logic    restart;
        logic    shift_push;
        logic    prod_rd;
        logic    pop;
        logic    top_rd;
        logic    act_rd_goto;
        logic    goto_push;
        logic    set_result;
        t_status result;
        logic    load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic              clear_last;
        t_req              req;
        logic [KIND_W-1:0] act_kind;
        logic              prod_ok;
        logic              stack_full;
        logic              reduce_bad;
        logic              elim;
        logic              out_free;
    } t_dp_stat;

endpackage

// ----- hdl/lps_ctrl.sv -----
// ----------------------------------------------------------------------------
// LALR parse step controller
// Sequences table clearing, request decoding and the dependent table lookups.
// ----------------------------------------------------------------------------
module lps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  lps_pkg::t_dp_stat  i_stat,
    output lps_pkg::t_ctrl_cmd o_cmd,
    output logic               o_in_stall
);
    import lps_pkg::*;

    t_fsm r_state;
    t_fsm n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_stat.req == REQ_TOKEN) ? S_ACT : S_RESP;
                end
            end
            S_ACT: begin
                if (i_stat.act_kind == KIND_REDUCE && i_stat.prod_ok) begin
                    n_state = S_PROD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_PROD: begin
                n_state = i_stat.reduce_bad ? S_RESP : S_TOP;
            end
            S_TOP: begin
                n_state = S_GOTO;
            end
            S_GOTO: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.result = RES_DONE;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    unique case (i_stat.req)
                        REQ_TOKEN: begin
                            o_cmd.act_rd_token = 1'b1;
                        end
                        REQ_WR_ACTION: begin
                            o_cmd.wr_action  = 1'b1;
                            o_cmd.set_result = 1'b1;
                        end
                        REQ_WR_PROD: begin
                            o_cmd.wr_prod    = 1'b1;
                            o_cmd.set_result = 1'b1;
                        end
                        REQ_RESTART: begin
                            o_cmd.restart    = 1'b1;
                            o_cmd.set_result = 1'b1;
                        end
                        default: begin
                            o_cmd.set_result = 1'b1;
                        end
                    endcase
                end
            end
            S_ACT: begin
                o_cmd.set_result = 1'b1;
                unique case (i_stat.act_kind)
                    KIND_NONE: begin
                        o_cmd.result = RES_SYNTAX;
                    end
                    KIND_ACCEPT: begin
                        o_cmd.result = RES_ACCEPT;
                    end
                    KIND_SHIFT: begin
                        if (i_stat.stack_full) begin
                            o_cmd.result = RES_INTERNAL;
                        end else begin
                            o_cmd.shift_push = 1'b1;
                            o_cmd.result     = RES_SHIFT;
                        end
                    end
                    KIND_REDUCE: begin
                        if (i_stat.prod_ok) begin
                            o_cmd.set_result = 1'b0;
                            o_cmd.prod_rd    = 1'b1;
                        end else begin
                            o_cmd.result = RES_INTERNAL;
                        end
                    end
                    default: begin
                        o_cmd.result = RES_INTERNAL;
                    end
                endcase
            end
            S_PROD: begin
                if (i_stat.reduce_bad) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.result     = RES_INTERNAL;
                end else begin
                    o_cmd.pop    = 1'b1;
                    o_cmd.top_rd = 1'b1;
                end
            end
            S_TOP: begin
                o_cmd.act_rd_goto = 1'b1;
            end
            S_GOTO: begin
                o_cmd.set_result = 1'b1;
                if (i_stat.act_kind == KIND_NONE) begin
                    o_cmd.result = RES_INTERNAL;
                end else begin
                    o_cmd.goto_push = 1'b1;
                    o_cmd.result    = i_stat.elim ? RES_RED_ELIM : RES_RED_NORMAL;
                end
            end
            S_RESP: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd.clear_en = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/lps_datapath.sv -----
// ----------------------------------------------------------------------------
// LALR parse step datapath
// Action, production and state stack memories, parser registers, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module lps_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lps_pkg::t_ctrl_cmd               i_cmd,
    output lps_pkg::t_dp_stat                o_stat,
    input  logic                             i_cfg_valid,
    input  logic [lps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [lps_pkg::REQ_W-1:0]        i_req_type,
    input  logic [lps_pkg::SYM_W-1:0]        i_symbol,
    input  logic [lps_pkg::STATE_W-1:0]      i_state_index,
    input  logic [lps_pkg::KIND_W-1:0]       i_action_kind,
    input  logic [lps_pkg::STATE_W-1:0]      i_action_value,
    input  logic [lps_pkg::PROD_W-1:0]       i_production_index,
    input  logic [lps_pkg::HEAD_W-1:0]       i_head_symbol,
    input  logic [lps_pkg::LEN_W-1:0]        i_handle_length,
    input  logic                             i_single_nonterminal,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [lps_pkg::STAT_W-1:0]       o_status,
    output logic [lps_pkg::STATE_W-1:0]      o_new_state,
    output logic [lps_pkg::PROD_W-1:0]       o_reduced_production,
    output logic [lps_pkg::SP_W-1:0]         o_stack_depth
);
    import lps_pkg::*;

    logic [ACT_DW-1:0]  r_act_mem [ACT_DEPTH];
    logic [PROD_DW-1:0] r_prod_mem [NUM_PRODUCTIONS];
    logic [STATE_W-1:0] r_stk_mem [STACK_DEPTH];

    logic               r_trim;
    logic [STATE_W-1:0] r_init;
    logic [SP_W-1:0]    r_sp;
    logic [STATE_W-1:0] r_cur;
    logic [ACT_AW-1:0]  r_clr_cnt;
    logic [ACT_DW-1:0]  r_act_rdata;
    logic [PROD_DW-1:0] r_prod_rdata;
    logic [STATE_W-1:0] r_stk_rdata;
    logic [PROD_W-1:0]  r_prod_num;
    t_status            r_result;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [STATE_W-1:0] r_out_state;
    logic [PROD_W-1:0]  r_out_prod;
    logic [SP_W-1:0]    r_out_depth;

    logic               act_we;
    logic               act_re;
    logic [ACT_AW-1:0]  act_addr;
    logic [ACT_DW-1:0]  act_wdata;
    logic [KIND_W-1:0]  act_kind;
    logic [STATE_W-1:0] act_val;
    logic [LEN_W-1:0]   sat_len;
    logic [HEAD_W-1:0]  prod_head;
    logic [LEN_W-1:0]   prod_len;
    logic               prod_single;
    logic               elim;
    logic [LEN_W-1:0]   pops;
    logic [SP_W:0]      sp_ext;
    logic [SP_W:0]      pops_ext;
    logic [SP_W:0]      room;
    logic               underflow;
    logic               overflow;
    logic [SP_W-1:0]    sp_pop;
    logic [SP_W-1:0]    sp_pop_m1;
    logic               stk_we;
    logic [STK_AW-1:0]  stk_waddr;
    logic [STATE_W-1:0] stk_wdata;
    logic               out_free;

    assign act_kind    = r_act_rdata[ACT_DW-1 -: KIND_W];
    assign act_val     = r_act_rdata[STATE_W-1:0];
    assign prod_head   = r_prod_rdata[PROD_DW-1 -: HEAD_W];
    assign prod_len    = r_prod_rdata[1 +: LEN_W];
    assign prod_single = r_prod_rdata[0];
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        act_we    = 1'b0;
        act_re    = 1'b0;
        act_addr  = {r_cur, i_symbol};
        act_wdata = '0;
        priority if (i_cmd.clear_en) begin
            act_we   = 1'b1;
            act_addr = r_clr_cnt;
        end else if (i_cmd.wr_action) begin
            act_we    = 1'b1;
            act_addr  = {i_state_index, i_symbol};
            act_wdata = {i_action_kind, i_action_value};
        end else if (i_cmd.act_rd_token) begin
            act_re = 1'b1;
        end else if (i_cmd.act_rd_goto) begin
            act_re   = 1'b1;
            act_addr = {r_stk_rdata, prod_head};
        end
    end

    always_ff @(posedge i_clk) begin
        if (act_we) begin
            r_act_mem[act_addr] <= act_wdata;
        end
        if (act_re) begin
            r_act_rdata <= r_act_mem[act_addr];
        end
    end

    assign sat_len = (i_handle_length > LEN_W'(MAX_HANDLE)) ? LEN_W'(MAX_HANDLE)
                                                             : i_handle_length;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_prod) begin
            r_prod_mem[i_production_index] <= {i_head_symbol, sat_len, i_single_nonterminal};
        end
        if (i_cmd.prod_rd) begin
            r_prod_rdata <= r_prod_mem[act_val[PROD_W-1:0]];
            r_prod_num   <= act_val[PROD_W-1:0];
        end
    end

    assign elim      = r_trim && prod_single;
    assign pops      = elim ? LEN_W'(1) : prod_len;
    assign sp_ext    = {1'b0, r_sp};
    assign pops_ext  = (SP_W + 1)'(pops);
    assign room      = sp_ext - pops_ext + (SP_W + 1)'(1);
    assign underflow = sp_ext < pops_ext + (SP_W + 1)'(1);
    assign overflow  = room > (SP_W + 1)'(STACK_DEPTH);
    assign sp_pop    = r_sp - SP_W'(pops);
    assign sp_pop_m1 = sp_pop - SP_W'(1);

    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = r_sp[STK_AW-1:0];
        stk_wdata = act_val;
        priority if (i_cmd.restart) begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = r_init;
        end else if (i_cmd.shift_push || i_cmd.goto_push) begin
            stk_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        if (i_cmd.top_rd) begin
            r_stk_rdata <= r_stk_mem[sp_pop_m1[STK_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_cur     <= '0;
            r_trim    <= 1'b0;
            r_init    <= '0;
            r_clr_cnt <= '0;
            r_result  <= RES_DONE;
        end else begin
            if (i_cmd.restart) begin
                r_sp  <= SP_W'(1);
                r_cur <= r_init;
            end else if (i_cmd.shift_push || i_cmd.goto_push) begin
                r_sp  <= r_sp + SP_W'(1);
                r_cur <= act_val;
            end else if (i_cmd.pop) begin
                r_sp <= sp_pop;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_TRIM) begin
                    r_trim <= i_cfg_data[0];
                end else if (i_cfg_index == CFG_INIT) begin
                    r_init <= i_cfg_data[STATE_W-1:0];
                end
            end
            if (i_cmd.clear_en) begin
                r_clr_cnt <= r_clr_cnt + ACT_AW'(1);
            end
            if (i_cmd.set_result) begin
                r_result <= i_cmd.result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_result;
            r_out_state  <= r_cur;
            r_out_depth  <= r_sp;
            if (r_result == RES_RED_NORMAL || r_result == RES_RED_ELIM) begin
                r_out_prod <= r_prod_num;
            end else begin
                r_out_prod <= '0;
            end
        end
    end

    assign o_stat.clear_last = &r_clr_cnt;
    assign o_stat.req        = t_req'(i_req_type);
    assign o_stat.act_kind   = act_kind;
    assign o_stat.prod_ok    = act_val < STATE_W'(NUM_PRODUCTIONS);
    assign o_stat.stack_full = r_sp >= SP_W'(STACK_DEPTH);
    assign o_stat.reduce_bad = underflow || overflow;
    assign o_stat.elim       = elim;
    assign o_stat.out_free   = out_free;

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_new_state          = r_out_state;
    assign o_reduced_production = r_out_prod;
    assign o_stack_depth        = r_out_depth;

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift_push || i_cmd.goto_push) |-> (r_sp < SP_W'(STACK_DEPTH)))
        else $error("stack push issued on a full stack");

    a_pop_leaves_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> (r_sp != '0 && r_sp < SP_W'(STACK_DEPTH)))
        else $error("reduce pop left the stack empty or without room for the goto");

    a_restart_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.restart |=> (r_sp == SP_W'(1) && r_cur == $past(r_init)))
        else $error("restart did not leave a single initial entry");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> out_free)
        else $error("output register overwritten while a result was still held");

endmodule

// ----- hdl/lalr_parse_step.sv -----
// ----------------------------------------------------------------------------
// LALR parse step
// Table-driven LALR driver: one parser step, table write or restart per
// transaction, one result transaction per request.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on i_in_valid/o_in_stall; results leave on
// o_out_valid/i_out_stall. A transaction moves when valid is high and stall
// is low. Configuration registers (trim, initial state) are written through
// i_cfg_valid/o_cfg_ready at any time, ready is always high; write them only
// while no request is in flight.
// After reset the action table is cleared one entry per cycle and the input
// is stalled until all 65536 entries are done. The production table and
// state stack are not cleared; a restart request must precede parsing.
// From the accepting edge to the output register: table writes and restart
// go straight to the response state; shift, accept and errors found at the
// action lookup pass the action read; a reduce refused by the stack check
// also the production read; a full reduce the action, production, stack top
// and goto reads, each a synchronous memory read. One request is processed at
// a time; the next is accepted once the result sits in the output register.
// A stalled receiver holds that register and the block waits with the next
// result until taken.
// ----------------------------------------------------------------------------
module lalr_parse_step (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [lps_pkg::REQ_W-1:0]        i_req_type,
    input  logic [lps_pkg::SYM_W-1:0]        i_symbol,
    input  logic [lps_pkg::STATE_W-1:0]      i_state_index,
    input  logic [lps_pkg::KIND_W-1:0]       i_action_kind,
    input  logic [lps_pkg::STATE_W-1:0]      i_action_value,
    input  logic [lps_pkg::PROD_W-1:0]       i_production_index,
    input  logic [lps_pkg::HEAD_W-1:0]       i_head_symbol,
    input  logic [lps_pkg::LEN_W-1:0]        i_handle_length,
    input  logic                             i_single_nonterminal,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [lps_pkg::STAT_W-1:0]       o_status,
    output logic [lps_pkg::STATE_W-1:0]      o_new_state,
    output logic [lps_pkg::PROD_W-1:0]       o_reduced_production,
    output logic [lps_pkg::SP_W-1:0]         o_stack_depth,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lps_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    assign o_cfg_ready = 1'b1;

    lps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lps_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_req_type           (i_req_type),
        .i_symbol             (i_symbol),
        .i_state_index        (i_state_index),
        .i_action_kind        (i_action_kind),
        .i_action_value       (i_action_value),
        .i_production_index   (i_production_index),
        .i_head_symbol        (i_head_symbol),
        .i_handle_length      (i_handle_length),
        .i_single_nonterminal (i_single_nonterminal),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_status             (o_status),
        .o_new_state          (o_new_state),
        .o_reduced_production (o_reduced_production),
        .o_stack_depth        (o_stack_depth)
    );

endmodule
